>>> hdl/btl_pkg.sv
// shared types, character codes and helpers for the brace token lexer
package btl_pkg;

    // lexer modes, one-hot
    typedef enum logic [7:0] {
        MODE_BETWEEN = 8'b0000_0001,
        MODE_SLASH   = 8'b0000_0010,
        MODE_LINE    = 8'b0000_0100,
        MODE_BLOCK   = 8'b0000_1000,
        MODE_BSTAR   = 8'b0001_0000,
        MODE_WORD    = 8'b0010_0000,
        MODE_STR     = 8'b0100_0000,
        MODE_ESC     = 8'b1000_0000
    } mode_t;

    // token kinds
    localparam logic [1:0] KIND_PUNCT = 2'd0;
    localparam logic [1:0] KIND_WORD  = 2'd1;
    localparam logic [1:0] KIND_STR   = 2'd2;

    // character codes
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // result queue depth and the width of its fill count
    localparam int unsigned QUEUE_DEPTH = 3;
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [1:0] token_kind;
        logic       token_first;
        logic       token_close;
        logic       run_last;
    } res_t;

    // up to two results caused by one input item
    typedef struct packed {
        logic valid0;
        logic valid1;
        res_t res0;
        res_t res1;
    } res_pair_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_COMMA);
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return is_space(c) || is_punct(c) || (c == CH_QUOTE);
    endfunction

    // build a result; the byte reads zero on a pure close marker
    function automatic res_t mk_res(input logic [7:0] b, input logic has,
                                    input logic [1:0] kind, input logic first,
                                    input logic close);
        res_t r;
        r.out_byte    = has ? b : 8'h00;
        r.has_byte    = has;
        r.token_kind  = kind;
        r.token_first = first;
        r.token_close = close;
        r.run_last    = 1'b0;
        return r;
    endfunction

endpackage

>>> hdl/btl_step.sv
// next-mode and result logic for one source byte
module btl_step (
    input  logic [7:0]         in_byte,
    input  logic               end_of_input,
    input  btl_pkg::mode_t     mode,
    input  logic               str_empty,
    output btl_pkg::mode_t     mode_next,
    output logic               str_empty_next,
    output btl_pkg::res_pair_t results
);

    // token start from between tokens
    logic             st_emit;
    btl_pkg::res_t    st_res;
    btl_pkg::mode_t   st_mode;
    logic             st_empty_set;
    logic [7:0]       esc_byte;
    btl_pkg::mode_t   mode_work;
    logic             empty_work;
    btl_pkg::res_pair_t rp;

    // what a byte does when no token is open
    always_comb begin
        st_emit      = 1'b0;
        st_res       = btl_pkg::mk_res(in_byte, 1'b1, btl_pkg::KIND_WORD, 1'b1,
                                       end_of_input);
        st_mode      = btl_pkg::MODE_BETWEEN;
        st_empty_set = 1'b0;
        if (btl_pkg::is_space(in_byte)) begin
            st_emit = 1'b0;
        end else if (btl_pkg::is_punct(in_byte)) begin
            st_emit = 1'b1;
            st_res  = btl_pkg::mk_res(in_byte, 1'b1, btl_pkg::KIND_PUNCT, 1'b1, 1'b1);
        end else if (in_byte == btl_pkg::CH_QUOTE) begin
            st_mode      = btl_pkg::MODE_STR;
            st_empty_set = 1'b1;
            st_emit      = end_of_input;
            st_res       = btl_pkg::mk_res(8'h00, 1'b0, btl_pkg::KIND_STR, 1'b1, 1'b1);
        end else if (in_byte == btl_pkg::CH_SLASH) begin
            st_emit = end_of_input;
            st_res  = btl_pkg::mk_res(in_byte, 1'b1, btl_pkg::KIND_WORD, 1'b1, 1'b1);
            st_mode = end_of_input ? btl_pkg::MODE_BETWEEN : btl_pkg::MODE_SLASH;
        end else begin
            st_emit = 1'b1;
            st_mode = btl_pkg::MODE_WORD;
        end
    end

    // escape decoding
    always_comb begin
        if (in_byte == btl_pkg::CH_LOWER_N) begin
            esc_byte = btl_pkg::CH_LF;
        end else if (in_byte == btl_pkg::CH_LOWER_T) begin
            esc_byte = btl_pkg::CH_TAB;
        end else begin
            esc_byte = in_byte;
        end
    end

    // per-mode transition and results
    always_comb begin
        rp.valid0  = 1'b0;
        rp.valid1  = 1'b0;
        rp.res0    = st_res;
        rp.res1    = st_res;
        mode_work  = mode;
        empty_work = str_empty;
        case (mode)
            btl_pkg::MODE_BETWEEN: begin
                rp.valid0  = st_emit;
                mode_work  = st_mode;
                empty_work = st_empty_set ? 1'b1 : str_empty;
            end
            btl_pkg::MODE_SLASH: begin
                if (in_byte == btl_pkg::CH_SLASH) begin
                    mode_work = btl_pkg::MODE_LINE;
                end else if (in_byte == btl_pkg::CH_STAR) begin
                    mode_work = btl_pkg::MODE_BLOCK;
                end else if (btl_pkg::is_delim(in_byte)) begin
                    rp.valid0  = 1'b1;
                    rp.res0    = btl_pkg::mk_res(btl_pkg::CH_SLASH, 1'b1,
                                                 btl_pkg::KIND_WORD, 1'b1, 1'b1);
                    rp.valid1  = st_emit;
                    mode_work  = st_mode;
                    empty_work = st_empty_set ? 1'b1 : str_empty;
                end else begin
                    rp.valid0 = 1'b1;
                    rp.res0   = btl_pkg::mk_res(btl_pkg::CH_SLASH, 1'b1,
                                                btl_pkg::KIND_WORD, 1'b1, 1'b0);
                    rp.valid1 = 1'b1;
                    rp.res1   = btl_pkg::mk_res(in_byte, 1'b1, btl_pkg::KIND_WORD,
                                                1'b0, end_of_input);
                    mode_work = btl_pkg::MODE_WORD;
                end
            end
            btl_pkg::MODE_LINE: begin
                if (in_byte == btl_pkg::CH_LF) begin
                    mode_work = btl_pkg::MODE_BETWEEN;
                end
            end
            btl_pkg::MODE_BLOCK: begin
                if (in_byte == btl_pkg::CH_STAR) begin
                    mode_work = btl_pkg::MODE_BSTAR;
                end
            end
            btl_pkg::MODE_BSTAR: begin
                if (in_byte == btl_pkg::CH_SLASH) begin
                    mode_work = btl_pkg::MODE_BETWEEN;
                end else if (in_byte != btl_pkg::CH_STAR) begin
                    mode_work = btl_pkg::MODE_BLOCK;
                end
            end
            btl_pkg::MODE_WORD: begin
                rp.valid0 = 1'b1;
                if (btl_pkg::is_delim(in_byte)) begin
                    rp.res0    = btl_pkg::mk_res(8'h00, 1'b0, btl_pkg::KIND_WORD,
                                                 1'b0, 1'b1);
                    rp.valid1  = st_emit;
                    mode_work  = st_mode;
                    empty_work = st_empty_set ? 1'b1 : str_empty;
                end else begin
                    rp.res0 = btl_pkg::mk_res(in_byte, 1'b1, btl_pkg::KIND_WORD,
                                              1'b0, end_of_input);
                end
            end
            btl_pkg::MODE_STR: begin
                if (in_byte == btl_pkg::CH_QUOTE) begin
                    rp.valid0  = 1'b1;
                    rp.res0    = btl_pkg::mk_res(8'h00, 1'b0, btl_pkg::KIND_STR,
                                                 str_empty, 1'b1);
                    empty_work = 1'b0;
                    mode_work  = btl_pkg::MODE_BETWEEN;
                end else if ((in_byte == btl_pkg::CH_BSLASH) && !end_of_input) begin
                    mode_work = btl_pkg::MODE_ESC;
                end else begin
                    // a trailing backslash stays literal
                    rp.valid0  = 1'b1;
                    rp.res0    = btl_pkg::mk_res(in_byte, 1'b1, btl_pkg::KIND_STR,
                                                 str_empty, end_of_input);
                    empty_work = 1'b0;
                end
            end
            btl_pkg::MODE_ESC: begin
                rp.valid0  = 1'b1;
                rp.res0    = btl_pkg::mk_res(esc_byte, 1'b1, btl_pkg::KIND_STR,
                                             str_empty, end_of_input);
                empty_work = 1'b0;
                mode_work  = btl_pkg::MODE_STR;
            end
            default: begin
                mode_work  = btl_pkg::MODE_BETWEEN;
                empty_work = 1'b0;
            end
        endcase

        // mark the last result of this item
        rp.res0.run_last = !rp.valid1;
        rp.res1.run_last = 1'b1;
    end

    // end of input always returns to between tokens
    assign mode_next      = end_of_input ? btl_pkg::MODE_BETWEEN : mode_work;
    assign str_empty_next = end_of_input ? 1'b0 : empty_work;
    assign results        = rp;

endmodule

>>> hdl/btl_outq.sv
// three-entry result queue that takes up to two results per cycle
module btl_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  btl_pkg::res_pair_t push_data,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output btl_pkg::res_t      out_data
);

    btl_pkg::res_t                   q_reg  [btl_pkg::QUEUE_DEPTH];
    btl_pkg::res_t                   q_next [btl_pkg::QUEUE_DEPTH];
    logic [btl_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [btl_pkg::QUEUE_CNT_W-1:0] count_next;
    logic [btl_pkg::QUEUE_CNT_W-1:0] base;
    logic                            pop;
    logic                            wr0;
    logic                            wr1;

    assign pop       = out_valid && out_ready;
    assign wr0       = push && push_data.valid0;
    assign wr1       = push && push_data.valid1;
    assign base      = count_reg - {{(btl_pkg::QUEUE_CNT_W-1){1'b0}}, pop};
    assign out_valid = (count_reg != '0);
    assign out_data  = q_reg[0];
    // room for two more results
    assign room      = (count_reg <= btl_pkg::QUEUE_CNT_W'(btl_pkg::QUEUE_DEPTH - 2));

    // shift out at the head, write behind the survivors
    always_comb begin
        for (int i = 0; i < btl_pkg::QUEUE_DEPTH; i++) begin
            q_next[i] = q_reg[i];
        end
        if (pop) begin
            for (int i = 0; i < btl_pkg::QUEUE_DEPTH - 1; i++) begin
                q_next[i] = q_reg[i + 1];
            end
        end
        for (int i = 0; i < btl_pkg::QUEUE_DEPTH; i++) begin
            if (wr0 && (base == btl_pkg::QUEUE_CNT_W'(i))) begin
                q_next[i] = push_data.res0;
            end
            if (wr1 && ((base + 1'b1) == btl_pkg::QUEUE_CNT_W'(i))) begin
                q_next[i] = push_data.res1;
            end
        end
        count_next = base + {{(btl_pkg::QUEUE_CNT_W-1){1'b0}}, wr0}
                          + {{(btl_pkg::QUEUE_CNT_W-1){1'b0}}, wr1};
    end

    // queue storage
    always_ff @(posedge aclk) begin
        for (int i = 0; i < btl_pkg::QUEUE_DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    // fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

>>> hdl/brace_token_lexer_unit.sv
// top level of the brace token lexer: mode registers, step logic, result queue
//
// Streaming tokenizer for brace-structured text with C-style comments. One
// source byte enters per item on the s_ side (s_tlast marks the last byte of
// a text); the lexer mode is held in a register and the step logic decides
// the next mode and up to two results combinationally, in the same cycle
// that the byte is taken. Results are registered in a three-entry queue
// that feeds the m_ side; s_tready is high while the queue has room for two
// more results, so with the output side always ready the block takes one
// byte per cycle and stalls after a byte that gives two results (a word or a
// pending slash ended by a punctuation byte or by a quote that ends the text,
// or a slash followed by a word byte). Comments and whitespace produce
// nothing; m_tlast marks the last result caused by a byte.
module brace_token_lexer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    // input item
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_input
    // result item
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [4:0] m_tuser,   // [0] has_byte, [2:1] token_kind, [3] token_first,
                                  // [4] token_close
    output logic       m_tlast    // run_last
);

    btl_pkg::mode_t     mode_reg;
    btl_pkg::mode_t     mode_next;
    logic               empty_reg;
    logic               empty_next;
    btl_pkg::res_pair_t results;
    btl_pkg::res_t      head;
    logic               accept;
    logic               room;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    // lexer step
    btl_step u_step (
        .in_byte        (s_tdata),
        .end_of_input   (s_tlast),
        .mode           (mode_reg),
        .str_empty      (empty_reg),
        .mode_next      (mode_next),
        .str_empty_next (empty_next),
        .results        (results)
    );

    // lexer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= btl_pkg::MODE_BETWEEN;
            empty_reg <= 1'b0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            empty_reg <= empty_next;
        end
    end

    // result queue
    btl_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (results),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    // output packing
    assign m_tdata = head.out_byte;
    assign m_tuser = {head.token_close, head.token_first, head.token_kind, head.has_byte};
    assign m_tlast = head.run_last;

endmodule
